// ----- rtl/toe_pkg.sv -----
// Shared constants, codes and types of the topological order engine.
`default_nettype none
package toe_pkg;

   localparam int NODES  = 16;
   localparam int NODE_W = 4;
   localparam int CNT_W  = 5;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_SORT  = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INDEG,
      ST_MARK,
      ST_SCAN,
      ST_FETCH,
      ST_APPLY,
      ST_EMIT,
      ST_CYCLE,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic start;
      logic shift;
      logic mark;
      logic apply;
      logic clear_edges;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/toe_cell.sv -----
// One node cell: its adjacency row, in-degree counter and ready flag on a ring.
`default_nettype none
module toe_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  toe_pkg::cell_ctl_type       ctl,
   input  logic [toe_pkg::NODE_W-1:0]  col_index,
   input  logic                        active,
   input  logic                        take,
   input  logic                        dec,
   input  logic [toe_pkg::NODES-1:0]   add_mask,
   input  logic [toe_pkg::NODES-1:0]   ring_row_in,
   input  logic                        ring_tag_in,
   output logic [toe_pkg::NODES-1:0]   ring_row_out,
   output logic                        ring_tag_out,
   output logic                        fresh
);
   import toe_pkg::*;

   logic [NODES-1:0] row_ff, row_in;
   logic             tag_ff, tag_in;
   logic [CNT_W-1:0] pend_ff, pend_in;
   logic             fresh_ff, fresh_in;

   always_comb begin
      row_in   = row_ff;
      tag_in   = tag_ff;
      pend_in  = pend_ff;
      fresh_in = fresh_ff;
      if (ctl.clear_edges) begin
         row_in = '0;
      end else if (ctl.shift) begin
         row_in = ring_row_in;
      end else begin
         row_in = row_ff | add_mask;
      end
      if (ctl.start) begin
         // The row held here belongs to this node; it counts only if the node is in range.
         tag_in   = active;
         pend_in  = '0;
         fresh_in = 1'b0;
      end else if (ctl.shift) begin
         tag_in = ring_tag_in;
         if (active && tag_ff && row_ff[col_index]) begin
            pend_in = pend_ff + CNT_W'(1);
         end
      end else if (ctl.mark) begin
         fresh_in = active && (pend_ff == '0);
      end else if (ctl.apply) begin
         if (active && dec && (pend_ff != '0)) begin
            pend_in = pend_ff - CNT_W'(1);
            if (pend_ff == CNT_W'(1)) begin
               fresh_in = 1'b1;
            end
         end
      end else if (take) begin
         fresh_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         tag_ff   <= 1'b0;
         pend_ff  <= '0;
         fresh_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         tag_ff   <= tag_in;
         pend_ff  <= pend_in;
         fresh_ff <= fresh_in;
      end
   end

   assign ring_row_out = row_ff;
   assign ring_tag_out = tag_ff;
   assign fresh        = fresh_ff;

endmodule
`default_nettype wire

// ----- rtl/toe_queue.sv -----
// First-in first-out queue of ready node indices with a registered read port.
`default_nettype none
module toe_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        push,
   input  logic [toe_pkg::NODE_W-1:0]  push_data,
   input  logic                        pop,
   output logic [toe_pkg::NODE_W-1:0]  pop_data,
   output logic                        empty
);
   import toe_pkg::*;

   logic [NODE_W-1:0] mem [NODES];
   logic [NODE_W-1:0] rd_ff;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  tail_ff, tail_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (clear) begin
         head_in = '0;
         tail_in = '0;
      end else begin
         if (push && (tail_ff < CNT_W'(NODES))) begin
            tail_in = tail_ff + CNT_W'(1);
         end
         if (pop) begin
            head_in = head_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !clear && (tail_ff < CNT_W'(NODES))) begin
         mem[tail_ff[NODE_W-1:0]] <= push_data;
      end
      if (pop) begin
         rd_ff <= mem[head_ff[NODE_W-1:0]];
      end
   end

   assign pop_data = rd_ff;
   assign empty    = (head_ff == tail_ff);

endmodule
`default_nettype wire

// ----- rtl/topological_order_engine.sv -----
// Topological order engine: edge loading and Kahn sort over a ring of node cells.
// Edge add and clear beats are taken only in the idle state and return nothing.
// A sort starts the cells, shifts the rows round the ring to count in-degrees, marks the
// ready nodes and scans them into the queue; each emitted node then takes a fetch, an apply, a scan and an emit.
// A full sort is paced by the scan, and an emit waits while the output register is full.
// Reset clears all edges, sets node_count to 16 and empties the output register.
`default_nettype none
module topological_order_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_func,
   input  logic [toe_pkg::NODE_W-1:0]  req_first_node,
   input  logic [toe_pkg::NODE_W-1:0]  req_second_node,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [toe_pkg::NODE_W-1:0]  rsp_node_index,
   output logic                        rsp_node_valid,
   output logic                        rsp_cycle_found,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [toe_pkg::CNT_W-1:0]   csr_data
);
   import toe_pkg::*;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] k_ff, k_in;
   logic [NODE_W-1:0] p_ff, p_in;
   logic              first_ff, first_in;
   logic [CNT_W-1:0]  emitted_count_ff, emitted_count_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0]  node_count_ff;

   logic [CNT_W-1:0]  n_eff;
   logic              req_accept;
   logic              add_en;
   logic [NODES-1:0]  b_onehot;
   cell_ctl_type      ctl;

   logic [NODES-1:0]  cell_row [NODES];
   logic [NODES-1:0]  cell_tag;
   logic [NODES-1:0]  cell_fresh;
   logic [NODES-1:0]  cur_row;
   logic              scan_en;

   logic              q_clear, q_push, q_pop, q_empty;
   logic [NODE_W-1:0] q_pop_data;

   logic              slot_free, sort_done, last_scan;
   logic              rsp_load;
   logic [NODE_W-1:0] load_index;
   logic              load_valid, load_cycle, load_last;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_index_ff;
   logic              rsp_nvalid_ff, rsp_cycle_ff, rsp_last_ff;

   assign n_eff      = (node_count_ff > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_ff;
   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign add_en     = req_accept && (req_func == FUNC_ADD)
                       && ({1'b0, req_first_node} < n_eff)
                       && ({1'b0, req_second_node} < n_eff);
   assign b_onehot   = NODES'(1) << req_second_node;
   assign cur_row    = cell_row[q_pop_data];
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign sort_done  = ((emitted_count_ff + CNT_W'(1)) == n_eff);
   assign last_scan  = ({1'b0, p_ff} == (n_eff - CNT_W'(1)));

   // Rows travel from each cell to the next one; sixteen shifts bring every row home.
   for (genvar i = 0; i < NODES; i++) begin : g_cell
      toe_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .col_index    (NODE_W'(i)),
         .active       (CNT_W'(i) < n_eff),
         .take         (scan_en && (p_ff == NODE_W'(i))),
         .dec          (cur_row[i]),
         .add_mask     ((add_en && (req_first_node == NODE_W'(i))) ? b_onehot : '0),
         .ring_row_in  (cell_row[(i + NODES - 1) % NODES]),
         .ring_tag_in  (cell_tag[(i + NODES - 1) % NODES]),
         .ring_row_out (cell_row[i]),
         .ring_tag_out (cell_tag[i]),
         .fresh        (cell_fresh[i])
      );
   end

   toe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .clear     (q_clear),
      .push      (q_push),
      .push_data (p_ff),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   always_comb begin
      state_in         = state_ff;
      k_in             = k_ff;
      p_in             = p_ff;
      first_in         = first_ff;
      emitted_count_in = emitted_count_ff;
      cur_in           = cur_ff;
      ctl              = '0;
      q_clear          = 1'b0;
      q_push           = 1'b0;
      q_pop            = 1'b0;
      scan_en          = 1'b0;
      rsp_load         = 1'b0;
      load_index       = '0;
      load_valid       = 1'b0;
      load_cycle       = 1'b0;
      load_last        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_func)
                  FUNC_CLEAR: begin
                     ctl.clear_edges = 1'b1;
                  end
                  FUNC_SORT: begin
                     ctl.start        = 1'b1;
                     q_clear          = 1'b1;
                     emitted_count_in = '0;
                     k_in             = '0;
                     state_in         = (n_eff == '0) ? ST_EMPTY : ST_INDEG;
                  end
                  default: ;
               endcase
            end
         end
         ST_INDEG: begin
            ctl.shift = 1'b1;
            k_in      = k_ff + NODE_W'(1);
            if (k_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            ctl.mark = 1'b1;
            p_in     = '0;
            first_in = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Ascending walk so that nodes freed together enter the queue by index.
            scan_en = 1'b1;
            q_push  = cell_fresh[p_ff];
            p_in    = p_ff + NODE_W'(1);
            if (last_scan) begin
               state_in = first_ff ? ST_FETCH : ST_EMIT;
            end
         end
         ST_FETCH: begin
            if (q_empty) begin
               state_in = ST_CYCLE;
            end else begin
               q_pop    = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            ctl.apply = 1'b1;
            cur_in    = q_pop_data;
            p_in      = '0;
            first_in  = 1'b0;
            state_in  = ST_SCAN;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_load         = 1'b1;
               load_index       = cur_ff;
               load_valid       = 1'b1;
               load_last        = q_empty && sort_done;
               emitted_count_in = emitted_count_ff + CNT_W'(1);
               if (!q_empty) begin
                  state_in = ST_FETCH;
               end else if (sort_done) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CYCLE;
               end
            end
         end
         ST_CYCLE: begin
            if (slot_free) begin
               rsp_load   = 1'b1;
               load_cycle = 1'b1;
               load_last  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               rsp_load  = 1'b1;
               load_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         k_ff             <= '0;
         p_ff             <= '0;
         first_ff         <= 1'b0;
         emitted_count_ff <= '0;
         cur_ff           <= '0;
         node_count_ff    <= CNT_W'(NODES);
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         k_ff             <= k_in;
         p_ff             <= p_in;
         first_ff         <= first_in;
         emitted_count_ff <= emitted_count_in;
         cur_ff           <= cur_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff  <= load_index;
         rsp_nvalid_ff <= load_valid;
         rsp_cycle_ff  <= load_cycle;
         rsp_last_ff   <= load_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = rsp_index_ff;
   assign rsp_node_valid  = rsp_nvalid_ff;
   assign rsp_cycle_found = rsp_cycle_ff;
   assign rsp_last        = rsp_last_ff;

   a_cycle_only_if_incomplete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CYCLE) |-> (emitted_count_ff != n_eff))
      else $error("cycle beat while every node was already emitted");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten before its beat was taken");

   a_emitted_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (emitted_count_ff <= n_eff))
      else $error("more nodes emitted than take part in the graph");

   a_popped_node_taken: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> !cell_fresh[q_pop_data])
      else $error("popped node still flagged as waiting for the queue");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the topological order engine: edge loads, clears and sorts.
`timescale 1ns / 1ps

module testbench;
   import toe_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int REQUEST_ITEMS  = 330;
   localparam int QUIET_CYCLES   = 40;
   localparam int TAIL_CYCLES    = 360;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [NODE_W-1:0] node_index;
      logic              node_valid;
      logic              cycle_found;
      logic              last;
   } order_beat_type;

   typedef struct packed {
      logic                 csr_write;
      logic [CNT_W-1:0]     csr_value;
      logic [1:0]           func;
      logic [NODE_W-1:0]    first_node;
      logic [NODE_W-1:0]    second_node;
      logic [2:0]           typed_count;
      order_beat_type [3:0] typed;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_func;
   logic [NODE_W-1:0] req_first_node;
   logic [NODE_W-1:0] req_second_node;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [NODE_W-1:0] rsp_node_index;
   logic              rsp_node_valid;
   logic              rsp_cycle_found;
   logic              rsp_last;
   logic              csr_valid;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_data;

   // Predictor state: adjacency rows (bit b of row a means a runs before b) and node count.
   logic [NODES-1:0]  edge_rows [NODES];
   logic [CNT_W-1:0]  node_limit;
   order_beat_type    order_expected [$];
   order_beat_type    front_beat;
   stim_row_type      stim_table [$];

   int  mismatch_count = 0;
   int  beats_checked = 0;
   int  cycle_reports = 0;
   int  useful_items = 0;
   int  req_beats = 0;
   int  sort_count = 0;
   int  csr_writes = 0;
   int  burst_left = 0;
   int  quiet_cycles = 0;
   int  stall_mode = 0;
   int  mode_left = 0;
   int  hold_asks = 0;
   int  holds_done = 0;

   topological_order_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_first_node  (req_first_node),
      .req_second_node (req_second_node),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_node_index  (rsp_node_index),
      .rsp_node_valid  (rsp_node_valid),
      .rsp_cycle_found (rsp_cycle_found),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic order_beat_type beat(input int idx, input int nv, input int cyc,
                                           input int fin);
      order_beat_type b;
      b.node_index  = idx[NODE_W-1:0];
      b.node_valid  = nv[0];
      b.cycle_found = cyc[0];
      b.last        = fin[0];
      return b;
   endfunction

   function automatic stim_row_type row(input logic csr_write,
                                        input logic [CNT_W-1:0] csr_value,
                                        input logic [1:0] func, input logic [NODE_W-1:0] a,
                                        input logic [NODE_W-1:0] b, input int typed_count = 0,
                                        input order_beat_type t0 = '0,
                                        input order_beat_type t1 = '0,
                                        input order_beat_type t2 = '0,
                                        input order_beat_type t3 = '0);
      stim_row_type r;
      r.csr_write   = csr_write;
      r.csr_value   = csr_value;
      r.func        = func;
      r.first_node  = a;
      r.second_node = b;
      r.typed_count = typed_count[2:0];
      r.typed[0]    = t0;
      r.typed[1]    = t1;
      r.typed[2]    = t2;
      r.typed[3]    = t3;
      return r;
   endfunction

   function automatic void add_expected(input order_beat_type b);
      order_expected.insert(order_expected.size(), b);
   endfunction

   function automatic void add_row(input stim_row_type r);
      stim_table.insert(stim_table.size(), r);
   endfunction

   function automatic int live_nodes();
      return (node_limit > NODES) ? NODES : int'(node_limit);
   endfunction

   // Kahn's algorithm with a FIFO of ready nodes; nodes freed together enter in index order.
   task automatic predict_kahn_order();
      int         n;
      int         head;
      int         tail;
      int         emitted;
      int         u;
      int         v;
      logic [4:0] indeg [NODES];
      logic [3:0] fifo [NODES];
      logic [3:0] cur;
      n = live_nodes();
      if (n == 0) begin
         add_expected(beat(0, 0, 0, 1));
         return;
      end
      for (v = 0; v < n; v++) begin
         indeg[v] = '0;
         for (u = 0; u < n; u++)
            indeg[v] += edge_rows[u][v];
      end
      head = 0;
      tail = 0;
      emitted = 0;
      for (v = 0; v < n; v++)
         if (indeg[v] == 0) begin
            fifo[tail] = v[3:0];
            tail++;
         end
      while (head < tail) begin
         cur = fifo[head];
         head++;
         add_expected(beat(int'(cur), 1, 0, 0));
         emitted++;
         for (v = 0; v < n; v++)
            if (edge_rows[cur][v] && indeg[v] > 0) begin
               indeg[v]--;
               if (indeg[v] == 0) begin
                  fifo[tail] = v[3:0];
                  tail++;
               end
            end
      end
      if (emitted == n)
         order_expected[order_expected.size() - 1].last = 1'b1;
      else
         add_expected(beat(0, 0, 1, 1));
   endtask

   // Offers one request beat in a burst pattern, then updates the predictor on acceptance.
   task automatic offer_beat(input logic [1:0] func, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input bit predicted);
      int gap;
      int n;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_valid       = 1'b1;
      req_func        = func;
      req_first_node  = a;
      req_second_node = b;
      do @(posedge clock); while (!req_ready);
      req_beats++;
      n = live_nodes();
      case (func)
         FUNC_ADD: begin
            if (a < n && b < n) begin
               edge_rows[a][b] = 1'b1;
               useful_items++;
            end
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < NODES; i++)
               edge_rows[i] = '0;
            useful_items++;
         end
         FUNC_SORT: begin
            if (predicted)
               predict_kahn_order();
            sort_count++;
            useful_items++;
         end
         default: ;
      endcase
   endtask

   // Holds off new requests until every expected beat is back and the block has gone quiet.
   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (order_expected.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      node_limit = value;
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Result receiver: random stall modes, plus one long hold on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 80);
         end
         mode_left--;
         case (stall_mode)
            0:       rsp_ready = 1'b1;
            1:       rsp_ready = ($urandom_range(0, 4) != 0);
            2:       rsp_ready = 1'($urandom_range(0, 1));
            default: rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (order_expected.size() == 0) begin
            $error("unexpected result beat: node_index %0d node_valid %0d cycle_found %0d last %0d",
                   rsp_node_index, rsp_node_valid, rsp_cycle_found, rsp_last);
            mismatch_count++;
         end else begin
            front_beat = order_expected.pop_front();
            if (rsp_node_index !== front_beat.node_index) begin
               $error("node_index: expected %0d, actual %0d", front_beat.node_index,
                      rsp_node_index);
               mismatch_count++;
            end
            if (rsp_node_valid !== front_beat.node_valid) begin
               $error("node_valid: expected %0d, actual %0d", front_beat.node_valid,
                      rsp_node_valid);
               mismatch_count++;
            end
            if (rsp_cycle_found !== front_beat.cycle_found) begin
               $error("cycle_found: expected %0d, actual %0d", front_beat.cycle_found,
                      rsp_cycle_found);
               mismatch_count++;
            end
            if (rsp_last !== front_beat.last) begin
               $error("last: expected %0d, actual %0d", front_beat.last, rsp_last);
               mismatch_count++;
            end
            beats_checked++;
            if (front_beat.cycle_found)
               cycle_reports++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int         phase_index;
      int         pick;
      int         n;
      int         edges;
      int         extra;
      int         i;
      int         j;
      int         k;
      bit         hold_phase;
      bit         acyclic;
      logic [3:0] t;
      logic [3:0] perm [NODES];
      logic [4:0] cfg;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_ADD;
      req_first_node  = '0;
      req_second_node = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      node_limit      = 5'd16;
      for (i = 0; i < NODES; i++)
         edge_rows[i] = '0;

      // Directed part: zero and single-node graphs, self edge, two-node loop, ignored
      // out-of-range and duplicate edges, unused code, stale edges, clamped node count.
      add_row(row(1'b1, 5'd0, FUNC_SORT, 4'd0, 4'd0, 1, beat(0, 0, 0, 1)));
      add_row(row(1'b1, 5'd1, FUNC_SORT, 4'd0, 4'd0, 1, beat(0, 1, 0, 1)));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd0, 4'd0));
      add_row(row(1'b0, 5'd0, FUNC_SORT, 4'd0, 4'd0, 1, beat(0, 0, 1, 1)));
      add_row(row(1'b1, 5'd2, FUNC_CLEAR, 4'd15, 4'd15));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd0, 4'd1));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd1, 4'd0));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd15, 4'd15));
      add_row(row(1'b0, 5'd0, FUNC_SORT, 4'd0, 4'd0, 1, beat(0, 0, 1, 1)));
      add_row(row(1'b1, 5'd16, FUNC_CLEAR, 4'd0, 4'd0));
      add_row(row(1'b0, 5'd0, FUNC_SORT, 4'd15, 4'd15));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd15, 4'd0));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd15, 4'd0));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd0, 4'd14));
      add_row(row(1'b0, 5'd0, FUNC_UNUSED, 4'd15, 4'd15));
      add_row(row(1'b0, 5'd0, FUNC_SORT, 4'd0, 4'd0));
      add_row(row(1'b1, 5'd31, FUNC_ADD, 4'd15, 4'd15));
      add_row(row(1'b0, 5'd0, FUNC_SORT, 4'd0, 4'd0));
      add_row(row(1'b1, 5'd4, FUNC_SORT, 4'd0, 4'd0, 4, beat(0, 1, 0, 0),
                  beat(1, 1, 0, 0), beat(2, 1, 0, 0), beat(3, 1, 0, 1)));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd3, 4'd2));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd2, 4'd1));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd1, 4'd0));
      add_row(row(1'b0, 5'd0, FUNC_SORT, 4'd0, 4'd0, 4, beat(3, 1, 0, 0),
                  beat(2, 1, 0, 0), beat(1, 1, 0, 0), beat(0, 1, 0, 1)));
      add_row(row(1'b1, 5'd17, FUNC_CLEAR, 4'd0, 4'd0));
      add_row(row(1'b0, 5'd0, FUNC_ADD, 4'd14, 4'd15));
      add_row(row(1'b0, 5'd0, FUNC_SORT, 4'd0, 4'd0));

      repeat (5) @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[r]) begin
         if (stim_table[r].csr_write) begin
            settle_block();
            write_node_count(stim_table[r].csr_value);
         end
         offer_beat(stim_table[r].func, stim_table[r].first_node, stim_table[r].second_node,
                    stim_table[r].typed_count == 0);
         for (k = 0; k < stim_table[r].typed_count; k++)
            add_expected(stim_table[r].typed[k]);
      end

      // Random part: each phase sets a node count, loads a graph and sorts it.
      phase_index = 0;
      while (req_beats < REQUEST_ITEMS) begin
         hold_phase = (phase_index == 2);
         settle_block();
         pick = $urandom_range(0, 19);
         if (hold_phase || pick == 2)
            cfg = 5'd16;
         else if (pick == 0)
            cfg = 5'd0;
         else if (pick == 1)
            cfg = 5'($urandom_range(17, 31));
         else if (pick < 6)
            cfg = 5'($urandom_range(1, 4));
         else
            cfg = 5'($urandom_range(2, 10));
         write_node_count(cfg);
         n = live_nodes();
         if ($urandom_range(0, 4) != 0)
            offer_beat(FUNC_CLEAR, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1);

         // Edges that follow a shuffled order cannot form a loop.
         acyclic = ($urandom_range(0, 9) < 7);
         for (i = 0; i < NODES; i++)
            perm[i] = i[3:0];
         for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
         end
         edges = (n < 2) ? $urandom_range(0, 1) : $urandom_range(1, 2 * n);
         for (k = 0; k < edges; k++) begin
            if (n == 0 || (acyclic && n == 1) || $urandom_range(0, 9) == 0) begin
               offer_beat($urandom_range(0, 1) ? FUNC_UNUSED : FUNC_ADD,
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1);
            end else if (acyclic) begin
               i = $urandom_range(0, n - 2);
               j = $urandom_range(i + 1, n - 1);
               offer_beat(FUNC_ADD, perm[i], perm[j], 1'b1);
            end else begin
               offer_beat(FUNC_ADD, 4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)),
                          1'b1);
            end
         end

         // In the hold phase the receiver stalls while more beats queue up behind the sort.
         if (hold_phase)
            hold_asks++;
         offer_beat(FUNC_SORT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1);
         if (hold_phase || $urandom_range(0, 4) == 0) begin
            extra = $urandom_range(1, 4);
            for (k = 0; k < extra; k++)
               offer_beat(FUNC_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          1'b1);
            offer_beat(FUNC_SORT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1);
         end
         phase_index++;
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (order_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d request beats, %0d of them effective, with %0d sorts over %0d writes.",
               req_beats, useful_items, sort_count, csr_writes);
      $display("Checked %0d result beats, %0d of them cycle reports; %0d mismatches.",
               beats_checked, cycle_reports, mismatch_count);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
